// File: rtl/core/hse_pkg.sv
// ----------------------------------------------------------------------------
// Hash set engine package
// Request and response types, command codes, sequencer states and the
// default sizes of the hash set engine.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int KEY_W = 20;
	localparam int CMD_W = 2;

	localparam int BUCKETS_DEF  = 1024;
	localparam int WAYS_DEF     = 4;
	localparam int KEY_BITS_DEF = 20;

	localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic was_present;
		logic status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_UPDATE
	} state_t;

endpackage

// File: rtl/core/hash_set_engine.sv
// ----------------------------------------------------------------------------
// Hash set engine
// A set of keys kept in bucket memories with a fixed number of ways per
// bucket, supporting add, remove and contains requests.
// ----------------------------------------------------------------------------
// Each request takes one bucket read and one write-back, so with a power-of-two
// bucket count a request passes through accept, memory read, and compare and
// write-back, and the next request is taken right after unless a held response
// is stalled; for any other bucket count a reciprocal multiplication with one
// correction step finds the bucket before the read. A finished response waits
// in an output register while the next request is already taken. After reset a
// clearing pass walks the valid memory one bucket per cycle, and no request is
// taken until it is done. An add of an absent key into a bucket whose ways are
// all in use is refused and reported through the status bit.
module hash_set_engine #(
	parameter int BUCKETS  = hse_pkg::BUCKETS_DEF,
	parameter int WAYS     = hse_pkg::WAYS_DEF,
	parameter int KEY_BITS = hse_pkg::KEY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hse_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hse_pkg::rsp_t rsp
);

	import hse_pkg::*;

	localparam int  BW        = $clog2(BUCKETS);
	localparam int  CW        = 2;
	localparam int  DIV_STEPS = 3;
	localparam bit  IS_POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam int  DW        = (KEY_BITS > BW) ? KEY_BITS + 1 : BW + 1;

	localparam longint unsigned     RECIP_L   = (64'd1 << KEY_BITS) / 64'(BUCKETS);
	localparam logic [KEY_BITS-1:0] RECIP     = KEY_BITS'(RECIP_L);
	localparam logic [KEY_BITS-1:0] BUCKETS_K = KEY_BITS'(BUCKETS);

	state_t state_q;
	state_t state_d;

	logic rd_en;
	logic clr_we;
	logic upd;
	logic commit;

	logic [BW-1:0]    clr_cnt_q;
	logic [CW-1:0]    div_cnt_q;
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BW-1:0]    bucket_q;

	logic [2*KEY_BITS-1:0] div_prod_q;
	logic [KEY_BITS-1:0]   div_quo;
	logic [KEY_BITS-1:0]   div_qb_q;
	logic [KEY_BITS-1:0]   div_diff;
	logic [DW-1:0]         div_diff_w;

	logic [KEY_BITS+KEY_W-1:0] key_ext;
	logic [KEY_BITS-1:0]       key_m;
	logic [KEY_BITS+BW-1:0]    key_wide;
	logic [BW-1:0]             rem_next;

	logic [WAYS-1:0]                vld_mem [BUCKETS];
	logic [WAYS-1:0][KEY_BITS-1:0]  key_mem [BUCKETS];
	logic [WAYS-1:0]                vld_rd_q;
	logic [WAYS-1:0][KEY_BITS-1:0]  key_rd_q;

	logic [WAYS-1:0]               hit_vec;
	logic [WAYS-1:0]               free_vec;
	logic [WAYS-1:0]               first_free;
	logic                          hit;
	logic [WAYS-1:0]               new_vld;
	logic                          ins;
	logic                          status_n;
	logic [WAYS-1:0][KEY_BITS-1:0] key_wdata;

	logic            vld_we;
	logic [BW-1:0]   vld_waddr;
	logic [WAYS-1:0] vld_wdata;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign key_ext  = {{KEY_BITS{1'b0}}, req.key};
	assign key_m    = key_ext[KEY_BITS-1:0];
	assign key_wide = {{BW{1'b0}}, key_m};

	// The estimated quotient is exact or one too small, so one subtraction
	// of the bucket count brings the remainder into range.
	assign div_quo    = div_prod_q[2*KEY_BITS-1:KEY_BITS];
	assign div_diff   = key_q - div_qb_q;
	assign div_diff_w = DW'(div_diff);
	always_comb begin
		if (div_diff_w >= DW'(BUCKETS)) begin
			rem_next = BW'(div_diff_w - DW'(BUCKETS));
		end else begin
			rem_next = BW'(div_diff_w);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == BW'(BUCKETS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = IS_POW2 ? S_READ : S_DIV;
			end
			S_DIV: begin
				if (div_cnt_q == CW'(1)) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (!rsp_valid_q || !rsp_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		clr_we    = 1'b0;
		upd       = 1'b0;
		unique case (state_q)
			S_CLEAR:  clr_we = 1'b1;
			S_IDLE:   req_stall = 1'b0;
			S_DIV:    ;
			S_READ:   rd_en = 1'b1;
			S_UPDATE: upd = 1'b1;
			default:  ;
		endcase
	end

	assign commit = upd && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) clr_cnt_q <= clr_cnt_q + BW'(1);
			if (state_q == S_IDLE && req_valid) begin
				div_cnt_q <= CW'(DIV_STEPS);
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q - CW'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q     <= req.cmd;
			key_q     <= key_m;
			bucket_q  <= key_wide[BW-1:0];
		end else if (state_q == S_DIV) begin
			if (div_cnt_q == CW'(3)) begin
				div_prod_q <= {{KEY_BITS{1'b0}}, key_q} * {{KEY_BITS{1'b0}}, RECIP};
			end
			if (div_cnt_q == CW'(2)) begin
				div_qb_q <= div_quo * BUCKETS_K;
			end
			if (div_cnt_q == CW'(1)) begin
				bucket_q <= rem_next;
			end
		end
		if (commit) begin
			rsp_q.was_present <= hit;
			rsp_q.status      <= status_n;
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vld_rd_q[w] && (key_rd_q[w] == key_q);
		end
	end

	assign hit        = |hit_vec;
	assign free_vec   = ~vld_rd_q;
	assign first_free = free_vec & (~free_vec + WAYS'(1));

	always_comb begin
		new_vld  = vld_rd_q;
		ins      = 1'b0;
		status_n = 1'b0;
		unique case (cmd_q)
			CMD_ADD: begin
				if (!hit) begin
					if (|free_vec) begin
						ins     = 1'b1;
						new_vld = vld_rd_q | first_free;
					end else begin
						status_n = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				new_vld = vld_rd_q & ~hit_vec;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			key_wdata[w] = first_free[w] ? key_q : key_rd_q[w];
		end
	end

	assign vld_we    = clr_we || commit;
	assign vld_waddr = clr_we ? clr_cnt_q : bucket_q;
	assign vld_wdata = clr_we ? '0 : new_vld;

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
		if (commit && ins) key_mem[bucket_q] <= key_wdata;
		if (rd_en) begin
			vld_rd_q <= vld_mem[bucket_q];
			key_rd_q <= key_mem[bucket_q];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid)
		else $error("Committed request did not produce a response.");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> req_stall)
		else $error("Request taken during the clearing pass.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_READ || state_q == S_DIV))
		else $error("Accepted request did not start a bucket lookup.");

	a_refused_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status) |-> !rsp.was_present)
		else $error("Refused add reported a present key.");

	a_refused_bucket_full: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && status_n) |-> (&vld_rd_q))
		else $error("Add refused while the bucket had a free way.");

endmodule

// File: dv/hse_checker.sv
// ----------------------------------------------------------------------------
// Hash set engine checker
// Watches the request and response channels of the hash set engine and
// keeps its own copy of the bucket ways. Every accepted request is applied
// to that copy to work out the expected response, which is queued. Every
// accepted response is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module hse_checker #(
	parameter int BUCKETS = hse_pkg::BUCKETS_DEF,
	parameter int WAYS    = hse_pkg::WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  hse_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  hse_pkg::rsp_t rsp,
	output int            fail_count,
	output int            open_count
);
	import hse_pkg::*;

	logic             held_valid [BUCKETS*WAYS];
	logic [KEY_W-1:0] held_key   [BUCKETS*WAYS];
	rsp_t             answers[$];
	int               errs = 0;

	assign fail_count = errs;

	function automatic rsp_t lookup_and_update(req_t r);
		int   base;
		int   hit_way;
		int   free_way;
		rsp_t ans;
		base     = int'(r.key % BUCKETS) * WAYS;
		hit_way  = -1;
		free_way = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (held_valid[base + w]) begin
				if (hit_way < 0 && held_key[base + w] == r.key)
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		ans.was_present = (hit_way >= 0);
		ans.status      = 1'b0;
		case (r.cmd)
			CMD_ADD: begin
				if (hit_way < 0) begin
					if (free_way >= 0) begin
						held_valid[base + free_way] = 1'b1;
						held_key[base + free_way]   = r.key;
					end else begin
						ans.status = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				if (hit_way >= 0)
					held_valid[base + hit_way] = 1'b0;
			end
			default: ;
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS*WAYS; i++)
				held_valid[i] = 1'b0;
			answers.delete();
			open_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answers.size() == 0) begin
					$error("response with no request outstanding: %b", rsp);
					errs++;
				end else begin
					want = answers.pop_front();
					if (rsp.was_present !== want.was_present) begin
						$error("was_present: expected %b, got %b", want.was_present,
							rsp.was_present);
						errs++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %b, got %b", want.status, rsp.status);
						errs++;
					end
				end
			end
			if (req_valid && !req_stall)
				answers.push_back(lookup_and_update(req));
			open_count <= answers.size();
		end
	end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Hash set engine testbench
// Drives add, remove and contains requests into the hash set engine, first
// a directed run over empty, full and refilled buckets, then random requests
// aimed at a few crowded buckets, under changing sender gaps and receiver
// stalls. The checker beside the engine predicts and compares responses.
// ----------------------------------------------------------------------------
module tb;
	import hse_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   stall_pct = 0;
	int   fail_count;
	int   open_count;

	int sender_idle [4] = '{0, 86, 0, 32};
	int recv_stall  [4] = '{0, 0, 86, 32};
	int hot_bucket  [4] = '{0, BUCKETS_DEF - 1, 341, 682};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	hash_set_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	hse_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	task automatic send_request(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
		input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req       <= {c, k};
		do @(posedge clk); while (req_stall);
	endtask

	function automatic logic [CMD_W-1:0] pick_cmd();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return CMD_ADD;
		else if (roll < 65)
			return CMD_REMOVE;
		else if (roll < 95)
			return CMD_CONTAINS;
		else
			return CMD_SPARE;
	endfunction

	// Most keys fall into a few buckets with a small pool of tags, so buckets
	// fill up, refuse adds and drain again.
	function automatic logic [KEY_W-1:0] pick_key();
		int tag;
		if ($urandom_range(7) == 0)
			return KEY_W'($urandom_range(20'hFFFFF));
		tag = $urandom_range(5) * 171;
		return KEY_W'(tag * BUCKETS_DEF + hot_bucket[$urandom_range(3)]);
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_CONTAINS, 20'h00000, 0);
		send_request(CMD_ADD,      20'h00000, 0);
		send_request(CMD_ADD,      20'h00000, 0);
		send_request(CMD_CONTAINS, 20'h00000, 0);
		send_request(CMD_ADD,      20'hFFFFF, 0);
		send_request(CMD_ADD,      20'h003FF, 0);
		send_request(CMD_ADD,      20'h7FFFF, 0);
		send_request(CMD_ADD,      20'h803FF, 0);
		send_request(CMD_ADD,      20'h403FF, 0);
		send_request(CMD_REMOVE,   20'h403FF, 0);
		send_request(CMD_REMOVE,   20'h7FFFF, 0);
		send_request(CMD_ADD,      20'h403FF, 0);
		send_request(CMD_CONTAINS, 20'h7FFFF, 0);
		send_request(CMD_CONTAINS, 20'h403FF, 0);
		send_request(CMD_SPARE,    20'hFFFFF, 0);
		send_request(CMD_SPARE,    20'h12345, 0);
		send_request(CMD_REMOVE,   20'h00000, 0);
		send_request(CMD_REMOVE,   20'h00000, 0);
		send_request(CMD_ADD,      20'h00400, 0);
		send_request(CMD_CONTAINS, 20'h00400, 0);
		send_request(CMD_REMOVE,   20'h00400, 0);
		send_request(CMD_CONTAINS, 20'h00400, 0);

		for (int p = 0; p < 4; p++) begin
			stall_pct <= recv_stall[p];
			repeat (238) send_request(pick_cmd(), pick_key(), sender_idle[p]);
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (open_count != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/core/hse_pkg.sv
rtl/core/hash_set_engine.sv
dv/hse_checker.sv
dv/tb.sv
